@@ sv/asc_pkg.sv @@
`timescale 1ns / 1ps

package asc_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int MAG_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * MAG_W - 1;
  localparam int SUM_W    = SQ_W + 2;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [R2_W-1:0]           r2_t;

  typedef enum logic [1:0] {
    REG_CENTRE_X      = 2'd0,
    REG_CENTRE_Y      = 2'd1,
    REG_CENTRE_Z      = 2'd2,
    REG_SPHERE_RADIUS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_PARTIAL = 2'd1,
    CLS_INSIDE  = 2'd2
  } cls_t;

endpackage

@@ sv/aabb_sphere_classify.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   box_min_{x,y,z}, box_max_{x,y,z}
// out_     output     out_valid/out_stall overlap_class
// cfg      APB write  psel/penable/pready centre_{x,y,z}, sphere_radius
//
// Four register stages: gaps, squares, sums, compare. One item per cycle while the output
// is not stalled; an accepted item passes through each stage in turn to the output register.
// Synchronous active-low reset empties the pipeline and zeroes the configuration registers.
// A stalled result holds; earlier stages keep filling until each slot is full.

module aabb_sphere_classify (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [23:0]         in_box_min_x,
  input  logic signed [23:0]         in_box_min_y,
  input  logic signed [23:0]         in_box_min_z,
  input  logic signed [23:0]         in_box_max_x,
  input  logic signed [23:0]         in_box_max_y,
  input  logic signed [23:0]         in_box_max_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_overlap_class,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [asc_pkg::ADDR_W-1:0] paddr,
  input  logic [asc_pkg::DATA_W-1:0] pwdata,
  output logic [asc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  asc_pkg::coord_t                   centre_x_r, centre_y_r, centre_z_r;
  logic [asc_pkg::RADIUS_W-1:0]      radius_r;
  logic                              wr_en;
  asc_pkg::reg_idx_t                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = asc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
      radius_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        asc_pkg::REG_CENTRE_X:      centre_x_r <= pwdata[asc_pkg::COORD_W-1:0];
        asc_pkg::REG_CENTRE_Y:      centre_y_r <= pwdata[asc_pkg::COORD_W-1:0];
        asc_pkg::REG_CENTRE_Z:      centre_z_r <= pwdata[asc_pkg::COORD_W-1:0];
        asc_pkg::REG_SPHERE_RADIUS: radius_r   <= pwdata[asc_pkg::RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (asc_pkg::reg_idx_t'(paddr[3:2]))
      asc_pkg::REG_CENTRE_X:      prdata = {{8{centre_x_r[23]}}, centre_x_r};
      asc_pkg::REG_CENTRE_Y:      prdata = {{8{centre_y_r[23]}}, centre_y_r};
      asc_pkg::REG_CENTRE_Z:      prdata = {{8{centre_z_r[23]}}, centre_z_r};
      asc_pkg::REG_SPHERE_RADIUS: prdata = {9'd0, radius_r};
      default:                    prdata = '0;
    endcase
  end

  function automatic asc_pkg::mag_t abs_diff(asc_pkg::coord_t a, asc_pkg::coord_t b);
    logic [asc_pkg::MAG_W-1:0] d;
    d = {a[23], a} - {b[23], b};
    return d[asc_pkg::MAG_W-1] ? asc_pkg::mag_t'(-d) : d;
  endfunction

  function automatic asc_pkg::mag_t axis_gap(asc_pkg::coord_t c, asc_pkg::coord_t lo,
                                             asc_pkg::coord_t hi);
    logic [asc_pkg::MAG_W-1:0] g;
    if (c < lo) begin
      g = {lo[23], lo} - {c[23], c};
    end else if (c > hi) begin
      g = {c[23], c} - {hi[23], hi};
    end else begin
      g = '0;
    end
    return g;
  endfunction

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: per-axis magnitudes
  asc_pkg::mag_t mn_x_r, mn_y_r, mn_z_r, mx_x_r, mx_y_r, mx_z_r;
  asc_pkg::mag_t gp_x_r, gp_y_r, gp_z_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      mn_x_r <= abs_diff(in_box_min_x, centre_x_r);
      mn_y_r <= abs_diff(in_box_min_y, centre_y_r);
      mn_z_r <= abs_diff(in_box_min_z, centre_z_r);
      mx_x_r <= abs_diff(in_box_max_x, centre_x_r);
      mx_y_r <= abs_diff(in_box_max_y, centre_y_r);
      mx_z_r <= abs_diff(in_box_max_z, centre_z_r);
      gp_x_r <= axis_gap(centre_x_r, in_box_min_x, in_box_max_x);
      gp_y_r <= axis_gap(centre_y_r, in_box_min_y, in_box_max_y);
      gp_z_r <= axis_gap(centre_z_r, in_box_min_z, in_box_max_z);
    end
  end

  // stage 2: squares
  asc_pkg::sq_t mn_x_sq_r, mn_y_sq_r, mn_z_sq_r, mx_x_sq_r, mx_y_sq_r, mx_z_sq_r;
  asc_pkg::sq_t gp_x_sq_r, gp_y_sq_r, gp_z_sq_r;
  asc_pkg::r2_t r2_s2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      mn_x_sq_r <= asc_pkg::SQ_W'(mn_x_r * mn_x_r);
      mn_y_sq_r <= asc_pkg::SQ_W'(mn_y_r * mn_y_r);
      mn_z_sq_r <= asc_pkg::SQ_W'(mn_z_r * mn_z_r);
      mx_x_sq_r <= asc_pkg::SQ_W'(mx_x_r * mx_x_r);
      mx_y_sq_r <= asc_pkg::SQ_W'(mx_y_r * mx_y_r);
      mx_z_sq_r <= asc_pkg::SQ_W'(mx_z_r * mx_z_r);
      gp_x_sq_r <= asc_pkg::SQ_W'(gp_x_r * gp_x_r);
      gp_y_sq_r <= asc_pkg::SQ_W'(gp_y_r * gp_y_r);
      gp_z_sq_r <= asc_pkg::SQ_W'(gp_z_r * gp_z_r);
      r2_s2_r   <= asc_pkg::R2_W'(radius_r * radius_r);
    end
  end

  // stage 3: sums
  asc_pkg::sum_t dmin_r, dmax_r, dist_r;
  asc_pkg::r2_t  r2_s3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      dmin_r  <= asc_pkg::SUM_W'(mn_x_sq_r) + asc_pkg::SUM_W'(mn_y_sq_r)
               + asc_pkg::SUM_W'(mn_z_sq_r);
      dmax_r  <= asc_pkg::SUM_W'(mx_x_sq_r) + asc_pkg::SUM_W'(mx_y_sq_r)
               + asc_pkg::SUM_W'(mx_z_sq_r);
      dist_r  <= asc_pkg::SUM_W'(gp_x_sq_r) + asc_pkg::SUM_W'(gp_y_sq_r)
               + asc_pkg::SUM_W'(gp_z_sq_r);
      r2_s3_r <= r2_s2_r;
    end
  end

  // stage 4: compare into the output register
  asc_pkg::cls_t cls_nxt, cls_r;
  asc_pkg::sum_t r2_ext;

  assign r2_ext = asc_pkg::SUM_W'(r2_s3_r);

  always_comb begin
    if (dmin_r < r2_ext && dmax_r < r2_ext) begin
      cls_nxt = asc_pkg::CLS_INSIDE;
    end else if (dist_r > r2_ext) begin
      cls_nxt = asc_pkg::CLS_OUTSIDE;
    end else begin
      cls_nxt = asc_pkg::CLS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_valid         = v4_r;
  assign out_overlap_class = cls_r;

`ifndef SYNTHESIS
  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (out_overlap_class != 2'd3))
    else $error("invalid class code");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with an empty slot");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (v3_r && $stable(dist_r)))
    else $error("stage 3 item lost under stall");
`endif

endmodule

@@ tb/sv/aabb_class_monitor.sv @@
`timescale 1ns / 1ps

module aabb_class_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  asc_pkg::coord_t            in_box_min_x,
  input  asc_pkg::coord_t            in_box_min_y,
  input  asc_pkg::coord_t            in_box_min_z,
  input  asc_pkg::coord_t            in_box_max_x,
  input  asc_pkg::coord_t            in_box_max_y,
  input  asc_pkg::coord_t            in_box_max_z,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_overlap_class,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [asc_pkg::ADDR_W-1:0] paddr,
  input  logic [asc_pkg::DATA_W-1:0] pwdata,
  output int                         fail_count,
  output int                         waiting,
  output int                         boxes_checked,
  output int                         seen_outside,
  output int                         seen_partial,
  output int                         seen_inside
);

  typedef struct {
    asc_pkg::coord_t min_x, min_y, min_z;
    asc_pkg::coord_t max_x, max_y, max_z;
  } box_t;

  typedef struct {
    box_t          box;
    asc_pkg::cls_t cls;
  } box_class_t;

  box_class_t                     pending_classes[$];
  asc_pkg::coord_t                ctr_x = '0;
  asc_pkg::coord_t                ctr_y = '0;
  asc_pkg::coord_t                ctr_z = '0;
  logic [asc_pkg::RADIUS_W-1:0]   radius = '0;
  int                             n_fail = 0;
  int                             n_done = 0;
  int                             n_out = 0;
  int                             n_part = 0;
  int                             n_in = 0;

  function automatic longint sx(asc_pkg::coord_t v);
    return v;
  endfunction

  function automatic longint sq_gap(longint a, longint b);
    return (a - b) * (a - b);
  endfunction

  // min is tested first, so an inverted box takes the gap to min when the centre is below it
  function automatic longint axis_gap_sq(longint c, longint lo, longint hi);
    if (c < lo) begin
      return sq_gap(lo, c);
    end else if (c > hi) begin
      return sq_gap(c, hi);
    end
    return 0;
  endfunction

  function automatic asc_pkg::cls_t classify_box(box_t b);
    longint cx, cy, cz, r2, d_lo, d_hi, d_box;
    cx    = sx(ctr_x);
    cy    = sx(ctr_y);
    cz    = sx(ctr_z);
    r2    = longint'(radius) * longint'(radius);
    d_lo  = sq_gap(sx(b.min_x), cx) + sq_gap(sx(b.min_y), cy) + sq_gap(sx(b.min_z), cz);
    d_hi  = sq_gap(sx(b.max_x), cx) + sq_gap(sx(b.max_y), cy) + sq_gap(sx(b.max_z), cz);
    if (d_lo < r2 && d_hi < r2) begin
      return asc_pkg::CLS_INSIDE;
    end
    d_box = axis_gap_sq(cx, sx(b.min_x), sx(b.max_x))
          + axis_gap_sq(cy, sx(b.min_y), sx(b.max_y))
          + axis_gap_sq(cz, sx(b.min_z), sx(b.max_z));
    return (d_box > r2) ? asc_pkg::CLS_OUTSIDE : asc_pkg::CLS_PARTIAL;
  endfunction

  always @(posedge clk) begin : watch
    box_t       b;
    box_class_t head;
    if (!rst_n) begin
      pending_classes.delete();
      ctr_x  = '0;
      ctr_y  = '0;
      ctr_z  = '0;
      radius = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (asc_pkg::reg_idx_t'(paddr[asc_pkg::ADDR_W-1:2]))
          asc_pkg::REG_CENTRE_X:      ctr_x  = pwdata[asc_pkg::COORD_W-1:0];
          asc_pkg::REG_CENTRE_Y:      ctr_y  = pwdata[asc_pkg::COORD_W-1:0];
          asc_pkg::REG_CENTRE_Z:      ctr_z  = pwdata[asc_pkg::COORD_W-1:0];
          asc_pkg::REG_SPHERE_RADIUS: radius = pwdata[asc_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        b.min_x = in_box_min_x;
        b.min_y = in_box_min_y;
        b.min_z = in_box_min_z;
        b.max_x = in_box_max_x;
        b.max_y = in_box_max_y;
        b.max_z = in_box_max_z;
        head.box = b;
        head.cls = classify_box(b);
        pending_classes.push_back(head);
      end
      if (out_valid && !out_stall) begin
        if (pending_classes.size() == 0) begin
          if (n_fail < 10) begin
            $display("[%0t] unexpected result: class %0d", $realtime, out_overlap_class);
          end
          n_fail++;
        end else begin
          head = pending_classes.pop_front();
          n_done++;
          case (head.cls)
            asc_pkg::CLS_OUTSIDE: n_out++;
            asc_pkg::CLS_PARTIAL: n_part++;
            default:              n_in++;
          endcase
          if (out_overlap_class !== head.cls) begin
            if (n_fail < 10) begin
              $display({"[%0t] mismatch: box min (%0d,%0d,%0d) max (%0d,%0d,%0d)",
                        " expected %0d got %0d"},
                       $realtime, head.box.min_x, head.box.min_y, head.box.min_z,
                       head.box.max_x, head.box.max_y, head.box.max_z,
                       head.cls, out_overlap_class);
            end
            n_fail++;
          end
        end
      end
    end
    fail_count    <= n_fail;
    waiting       <= pending_classes.size();
    boxes_checked <= n_done;
    seen_outside  <= n_out;
    seen_partial  <= n_part;
    seen_inside   <= n_in;
  end

endmodule

@@ tb/sv/aabb_sphere_classify_tb.sv @@
`timescale 1ns / 1ps

module aabb_sphere_classify_tb;

  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;
  localparam longint RMAX = 8388607;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  asc_pkg::coord_t              in_box_min_x, in_box_min_y, in_box_min_z;
  asc_pkg::coord_t              in_box_max_x, in_box_max_y, in_box_max_z;
  logic                         out_valid;
  logic                         out_stall;
  logic [1:0]                   out_overlap_class;
  logic                         psel, penable, pwrite;
  logic [asc_pkg::ADDR_W-1:0]   paddr;
  logic [asc_pkg::DATA_W-1:0]   pwdata;
  logic [asc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  int                   fail_count, waiting, boxes_checked;
  int                   seen_outside, seen_partial, seen_inside;

  bit                   in_idle_en = 1'b1;
  bit                   out_idle_en = 1'b1;
  int                   hold_len = 0;
  int                   n_settings = 0;
  longint               cur_cx = 0, cur_cy = 0, cur_cz = 0, cur_r = 0;

  aabb_sphere_classify u_top (.*);

  aabb_class_monitor u_monitor (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("aabb_sphere_classify_tb: FAIL");
    $finish;
  end

  // output side: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len = hold_len - 1;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst = burst - 1;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic asc_pkg::coord_t to_coord(longint v);
    if (v > CMAX) return asc_pkg::coord_t'(CMAX);
    if (v < CMIN) return asc_pkg::coord_t'(CMIN);
    return asc_pkg::coord_t'(v);
  endfunction

  function automatic longint rand_coord();
    asc_pkg::coord_t c;
    c = asc_pkg::coord_t'($urandom);
    return c;
  endfunction

  function automatic longint rand_off(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic send_box(input longint mnx, mny, mnz, mxx, mxy, mxz);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_box_min_x <= to_coord(mnx);
    in_box_min_y <= to_coord(mny);
    in_box_min_z <= to_coord(mnz);
    in_box_max_x <= to_coord(mxx);
    in_box_max_y <= to_coord(mxy);
    in_box_max_z <= to_coord(mxz);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_near(input longint a, b, c, d, e, f);
    send_box(cur_cx + a, cur_cy + b, cur_cz + c, cur_cx + d, cur_cy + e, cur_cz + f);
  endtask

  task automatic maybe_gap();
    int n;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input asc_pkg::reg_idx_t idx,
                           input logic [asc_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= asc_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // junk above each register's width must be dropped
  task automatic set_sphere(input longint cx, cy, cz, r);
    drain();
    cfg_write(asc_pkg::REG_CENTRE_X, {8'($urandom), 24'(cx)});
    cfg_write(asc_pkg::REG_CENTRE_Y, {8'($urandom), 24'(cy)});
    cfg_write(asc_pkg::REG_CENTRE_Z, {8'($urandom), 24'(cz)});
    cfg_write(asc_pkg::REG_SPHERE_RADIUS, {9'($urandom), 23'(r)});
    cur_cx = cx;
    cur_cy = cy;
    cur_cz = cz;
    cur_r  = r;
    n_settings++;
  endtask

  task automatic set_random_sphere();
    longint c[3];
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1)) c[k] = rand_coord();
      else c[k] = longint'($urandom_range(0, 8192)) - 4096;
    end
    set_sphere(c[0], c[1], c[2],
               longint'($urandom_range(0, 32'(RMAX))) >> $urandom_range(0, 22));
  endtask

  task automatic send_random_box();
    longint ctr[3], lo[3], hi[3], a, b, span, h;
    int     mode;
    ctr  = '{cur_cx, cur_cy, cur_cz};
    span = 2 * cur_r + 16;
    h    = cur_r / 2;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0, 1: begin
          lo[k] = rand_coord();
          hi[k] = rand_coord();
        end
        6, 7: begin
          lo[k] = ctr[k] - longint'($urandom_range(0, 32'(h)));
          hi[k] = ctr[k] + longint'($urandom_range(0, 32'(h)));
        end
        9: begin
          case ($urandom_range(0, 4))
            0: lo[k] = CMIN;
            1: lo[k] = CMAX;
            2: lo[k] = 0;
            3: lo[k] = -1;
            default: lo[k] = ctr[k];
          endcase
          hi[k] = $urandom_range(0, 1) ? CMAX : ctr[k] + rand_off(span);
        end
        default: begin
          a = ctr[k] + rand_off(span);
          b = ctr[k] + rand_off(span);
          // mode 8 keeps the corners swapped
          if ((a <= b) == (mode != 8)) begin
            lo[k] = a;
            hi[k] = b;
          end else begin
            lo[k] = b;
            hi[k] = a;
          end
        end
      endcase
    end
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_box_min_x = '0;
    in_box_min_y = '0;
    in_box_min_z = '0;
    in_box_max_x = '0;
    in_box_max_y = '0;
    in_box_max_z = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: zero radius, so a point on the centre is only partial
    send_box(0, 0, 0, 0, 0, 0);
    send_box(0, 0, 0, 1, 1, 1);
    send_box(1, 0, 0, 1, 0, 0);

    set_sphere(256, -512, 768, 1024);
    send_near(0, 0, 0, 0, 0, 0);
    send_near(-1024, 0, 0, 1, 1, 1);
    send_near(-600, -600, -600, 600, 600, 600);
    send_near(-500, -500, -500, 500, 500, 500);
    send_near(1024, -5, -5, 2000, 5, 5);
    send_near(1025, -5, -5, 2000, 5, 5);
    maybe_gap();
    send_near(-2000, -2000, -5, -724, -724, 5);
    send_near(3000, 0, 0, -3000, 0, 0);
    send_near(500, 0, 0, -5000, 0, 0);
    send_near(-500, 0, 0, -5000, 0, 0);
    send_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_box(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);

    set_sphere(CMIN, CMIN, CMIN, RMAX);
    send_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_box(CMIN + RMAX, CMIN, CMIN, CMAX, CMAX, CMAX);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_sphere(CMAX, CMAX, CMAX, 0);
        1: set_sphere(CMIN, CMIN, CMIN, RMAX);
        2: set_sphere(CMAX, CMIN, 0, RMAX);
        default: set_random_sphere();
      endcase
      if (p == 3) begin
        // stall the output long enough to back the pipeline up into the input
        @(posedge clk);
        hold_len = 300;
        repeat (40) send_random_box();
        drain();
      end
      if (p == 7) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end
      repeat (150) begin
        maybe_gap();
        send_random_box();
      end
    end

    drain();
    repeat (12) @(posedge clk);
    $display("Checked %0d boxes against %0d sphere settings, with idle and backlog phases.",
             boxes_checked, n_settings);
    $display("Outcomes: %0d outside, %0d partial, %0d inside.",
             seen_outside, seen_partial, seen_inside);
    if (fail_count == 0 && waiting == 0) begin
      $display("aabb_sphere_classify_tb: PASS");
    end else begin
      $display("aabb_sphere_classify_tb: FAIL");
    end
    $finish;
  end

endmodule
